// ===== rtl/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// Used by skt_cmp, skt_seq and sorted_key_table; no dependencies.
package skt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int KEY_BITS    = 64;

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int POS_W    = 32;
   localparam int ENTRY_W  = KEY_BITS + POS_W;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 6;
   localparam int FILL_W   = 7;
   localparam int KEY_IN_W = 64;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_DELETE = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_DUPLICATE = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_type;

   typedef struct packed {
      status_type           status;
      logic [IDX_W-1:0]     slot;
      logic [POS_W-1:0]     found_pos;
      logic [CNT_W-1:0]     fill;
   } rsp_type;

endpackage

// ===== rtl/skt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/skt_cmp.sv =====
// Shared key comparator used by every search probe.
// Depends on skt_pkg.
module skt_cmp (
   input  logic [skt_pkg::KEY_BITS-1:0] key_a,
   input  logic [skt_pkg::KEY_BITS-1:0] key_b,
   output skt_pkg::cmp_type             result
);

   always_comb begin
      result.eq = (key_a == key_b);
      result.lt = (key_a < key_b);
   end

endmodule

// ===== rtl/skt_seq.sv =====
// Sequencer for search, shift-up insert and shift-down delete over the entry RAM.
// Depends on skt_pkg, skt_ram and skt_cmp.
module skt_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  skt_pkg::mode_type            start_mode,
   input  logic [skt_pkg::KEY_BITS-1:0] start_key,
   input  logic [skt_pkg::POS_W-1:0]    start_pos,
   output logic                         idle,
   output logic                         done,
   input  logic                         take,
   output skt_pkg::rsp_type             result
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_SEARCH   = 8'b0000_0010,
      S_CMP      = 8'b0000_0100,
      S_DECIDE   = 8'b0000_1000,
      S_SHIFT_UP = 8'b0001_0000,
      S_SHIFT_DN = 8'b0010_0000,
      S_PLACE    = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type                      state_ff, state_in;
   skt_pkg::mode_type              mode_ff, mode_in;
   logic [skt_pkg::KEY_BITS-1:0]   key_ff, key_in;
   logic [skt_pkg::POS_W-1:0]      rpos_ff, rpos_in;
   logic [skt_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [skt_pkg::CNT_W-1:0]      lo_ff, lo_in;
   logic [skt_pkg::CNT_W-1:0]      hi_ff, hi_in;
   logic [skt_pkg::IDX_W-1:0]      mid_ff, mid_in;
   logic                           hit_ff, hit_in;
   logic [skt_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [skt_pkg::IDX_W-1:0]      ptr_ff, ptr_in;
   skt_pkg::status_type            status_ff, status_in;
   logic [skt_pkg::IDX_W-1:0]      slot_ff, slot_in;
   logic [skt_pkg::POS_W-1:0]      fpos_ff, fpos_in;

   logic                           wr_en;
   logic [skt_pkg::IDX_W-1:0]      wr_addr;
   logic [skt_pkg::ENTRY_W-1:0]    wr_data;
   logic [skt_pkg::IDX_W-1:0]      rd_addr;
   logic [skt_pkg::ENTRY_W-1:0]    rd_data;
   logic [skt_pkg::KEY_BITS-1:0]   rd_key;
   logic [skt_pkg::POS_W-1:0]      rd_pos;
   skt_pkg::cmp_type               cmp;

   logic [skt_pkg::CNT_W:0]        mid_sum;
   logic [skt_pkg::IDX_W-1:0]      mid_calc;
   logic [skt_pkg::IDX_W-1:0]      ptr_m1;
   logic [skt_pkg::IDX_W-1:0]      ptr_m2;
   logic [skt_pkg::CNT_W:0]        idx_p1;
   logic [skt_pkg::CNT_W:0]        ptr_p2;

   skt_ram #(
      .WIDTH (skt_pkg::ENTRY_W),
      .DEPTH (skt_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key = rd_data[skt_pkg::KEY_BITS-1:0];
   assign rd_pos = rd_data[skt_pkg::ENTRY_W-1:skt_pkg::KEY_BITS];

   skt_cmp u_cmp (
      .key_a  (key_ff),
      .key_b  (rd_key),
      .result (cmp)
   );

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = skt_pkg::IDX_W'(mid_sum >> 1);
   assign ptr_m1   = ptr_ff - 1'b1;
   assign ptr_m2   = ptr_ff - 2'd2;
   assign idx_p1   = (skt_pkg::CNT_W + 1)'(idx_ff) + 1'b1;
   assign ptr_p2   = (skt_pkg::CNT_W + 1)'(ptr_ff) + 2'd2;

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      key_in    = key_ff;
      rpos_in   = rpos_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      hit_in    = hit_ff;
      idx_in    = idx_ff;
      ptr_in    = ptr_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      fpos_in   = fpos_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff;
      wr_data   = rd_data;
      rd_addr   = ptr_m2;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = start_mode;
               key_in   = start_key;
               rpos_in  = start_pos;
               lo_in    = '0;
               hi_in    = count_ff;
               hit_in   = 1'b0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // hi is exclusive: the window is empty once lo reaches it
            if (lo_ff < hi_ff) begin
               rd_addr  = mid_calc;
               mid_in   = mid_calc;
               state_in = S_CMP;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_CMP: begin
            if (cmp.eq) begin
               hit_in   = 1'b1;
               idx_in   = mid_ff;
               fpos_in  = rd_pos;
               state_in = S_DECIDE;
            end else if (cmp.lt) begin
               hi_in    = skt_pkg::CNT_W'(mid_ff);
               state_in = S_SEARCH;
            end else begin
               lo_in    = skt_pkg::CNT_W'(mid_ff) + 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_DECIDE: begin
            unique case (mode_ff)
               skt_pkg::MODE_INSERT: begin
                  if (hit_ff) begin
                     status_in = skt_pkg::STATUS_DUPLICATE;
                     slot_in   = idx_ff;
                     state_in  = S_DONE;
                  end else if (count_ff >= skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH)) begin
                     status_in = skt_pkg::STATUS_FULL;
                     slot_in   = '0;
                     fpos_in   = '0;
                     state_in  = S_DONE;
                  end else begin
                     // lo is the insertion point once the search misses
                     status_in = skt_pkg::STATUS_OK;
                     slot_in   = skt_pkg::IDX_W'(lo_ff);
                     fpos_in   = rpos_ff;
                     ptr_in    = skt_pkg::IDX_W'(count_ff);
                     if (count_ff == lo_ff) begin
                        state_in = S_PLACE;
                     end else begin
                        rd_addr  = skt_pkg::IDX_W'(count_ff - 1'b1);
                        state_in = S_SHIFT_UP;
                     end
                  end
               end
               skt_pkg::MODE_DELETE: begin
                  if (!hit_ff) begin
                     status_in = skt_pkg::STATUS_NOT_FOUND;
                     slot_in   = '0;
                     fpos_in   = '0;
                     state_in  = S_DONE;
                  end else begin
                     status_in = skt_pkg::STATUS_OK;
                     slot_in   = idx_ff;
                     ptr_in    = idx_ff;
                     if (idx_p1 < (skt_pkg::CNT_W + 1)'(count_ff)) begin
                        rd_addr  = skt_pkg::IDX_W'(idx_p1);
                        state_in = S_SHIFT_DN;
                     end else begin
                        count_in = count_ff - 1'b1;
                        state_in = S_DONE;
                     end
                  end
               end
               default: begin
                  if (hit_ff) begin
                     status_in = skt_pkg::STATUS_OK;
                     slot_in   = idx_ff;
                  end else begin
                     status_in = skt_pkg::STATUS_NOT_FOUND;
                     slot_in   = '0;
                     fpos_in   = '0;
                  end
                  state_in = S_DONE;
               end
            endcase
         end
         S_SHIFT_UP: begin
            // write the entry read last cycle one slot higher, fetch the next lower one
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            ptr_in  = ptr_m1;
            rd_addr = ptr_m2;
            if (skt_pkg::CNT_W'(ptr_m1) == lo_ff) begin
               state_in = S_PLACE;
            end
         end
         S_SHIFT_DN: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            ptr_in  = ptr_ff + 1'b1;
            rd_addr = skt_pkg::IDX_W'(ptr_p2);
            if (ptr_p2 >= (skt_pkg::CNT_W + 1)'(count_ff)) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = skt_pkg::IDX_W'(lo_ff);
            wr_data  = {rpos_ff, key_ff};
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      rpos_ff   <= rpos_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      idx_ff    <= idx_in;
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      fpos_ff   <= fpos_in;
   end

   assign idle             = (state_ff == S_IDLE);
   assign done             = (state_ff == S_DONE);
   assign result.status    = status_ff;
   assign result.slot      = slot_ff;
   assign result.found_pos = fpos_ff;
   assign result.fill      = count_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH))
      else $error("entry count above table depth");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SHIFT_UP || state_ff == S_SHIFT_DN || state_ff == S_PLACE))
      else $error("RAM write outside shift or place");

   a_count_on_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> state_ff == S_DONE)
      else $error("entry count changed outside completion");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH || state_ff == S_CMP) |-> (lo_ff <= hi_ff && hi_ff <= count_ff))
      else $error("search window out of order");
`endif

endmodule

// ===== rtl/sorted_key_table.sv =====
// Sorted key table: a lookup makes at most IDX_W+1 probes (7 at depth 64) before its result.
// Insert then moves each larger entry up one slot and places the key; delete moves each
// later entry down one slot. The most entries move on an insert at slot 0 beside 63 entries
// and on a delete of slot 0 from a full table.
// One item at a time: the next beat is taken the cycle after the result moves to the output
// register, even while it waits there. Synchronous reset empties the table; RAM is not cleared.
module sorted_key_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [63:0] key, [95:64] record_pos
   input  logic [skt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] mode
   input  logic [skt_pkg::MODE_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [5:0] slot, [37:6] found_pos, [44:38] fill, [47:45] zero
   output logic [skt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [skt_pkg::STATUS_W-1:0]     rsp_tuser
);

   logic                  seq_idle;
   logic                  seq_done;
   logic                  take;
   logic                  start;
   skt_pkg::rsp_type      seq_rsp;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   skt_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   assign req_tready = seq_idle;
   assign start      = req_tvalid && seq_idle;
   // hand over the result only when the output register is free this cycle
   assign take       = seq_done && (!rsp_tvalid_ff || rsp_tready);

   skt_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_mode (skt_pkg::mode_type'(req_tuser)),
      .start_key  (req_tdata[skt_pkg::KEY_BITS-1:0]),
      .start_pos  (req_tdata[skt_pkg::KEY_IN_W +: skt_pkg::POS_W]),
      .idle       (seq_idle),
      .done       (seq_done),
      .take       (take),
      .result     (seq_rsp)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      if (take) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = seq_rsp;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {
      3'b000,
      skt_pkg::FILL_W'(rsp_data_ff.fill),
      rsp_data_ff.found_pos,
      skt_pkg::SLOT_W'(rsp_data_ff.slot)
   };

`ifndef NO_ASSERTIONS
   a_take_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |=> !$past(take))
      else $error("result handed over while output register busy");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && seq_done) |-> !start)
      else $error("new beat started while a result is pending inside");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid_ff)
      else $error("handed-over result not presented");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for sorted_key_table: lookup, insert and delete beats
// checked against a sorted-table predictor, with random idling on both streams.
// Depends on skt_pkg and the sorted_key_table RTL.
`timescale 1ns / 1ps

module testbench;

   localparam logic [skt_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;  // unused code, acts as lookup
   localparam int RESET_CYCLES   = 10;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_COUNT    = 4;
   localparam int FILL_BEATS     = 100;
   localparam int DRAIN_BEATS    = 30;

   typedef struct {
      logic [skt_pkg::MODE_W-1:0] mode;
      logic [63:0]                key;
      logic [skt_pkg::POS_W-1:0]  pos;
      int                         phase;
   } table_request_type;

   typedef struct {
      skt_pkg::status_type         status;
      logic [skt_pkg::SLOT_W-1:0]  slot;
      logic [skt_pkg::POS_W-1:0]   found_pos;
      logic [skt_pkg::FILL_W-1:0]  fill;
   } table_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [skt_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // [63:0] key, [95:64] record_pos
   logic [skt_pkg::MODE_W-1:0]     req_tuser = '0;   // [1:0] mode
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [skt_pkg::RSP_DATA_W-1:0] rsp_tdata;        // [5:0] slot, [37:6] found_pos, [44:38] fill
   logic [skt_pkg::STATUS_W-1:0]   rsp_tuser;        // [1:0] status

   table_request_type pending_requests[$];
   table_result_type  expected_results[$];
   logic [63:0]       live_keys[$];           // keys the stimulus expects to be present

   logic [63:0]               table_key[skt_pkg::TABLE_DEPTH];
   logic [skt_pkg::POS_W-1:0] table_pos[skt_pkg::TABLE_DEPTH];
   int                        table_fill = 0;

   int error_count = 0;
   int request_count = 0;
   int response_count = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   int drive_phase = 0;
   int quiet_cycles = 0;

   sorted_key_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic bit search_table(input logic [63:0] key, output int where);
      int lo, hi, mid;
      lo = 0;
      hi = table_fill - 1;
      where = 0;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (key == table_key[mid]) begin
            where = mid;
            return 1'b1;
         end
         if (key < table_key[mid]) hi = mid - 1;
         else lo = mid + 1;
      end
      return 1'b0;
   endfunction

   function automatic table_result_type apply_to_table(
         input logic [skt_pkg::MODE_W-1:0] mode,
         input logic [63:0] key,
         input logic [skt_pkg::POS_W-1:0] pos);
      table_result_type res;
      int at;
      bit hit;
      res.status = skt_pkg::STATUS_OK;
      res.slot = '0;
      res.found_pos = '0;
      hit = search_table(key, at);
      if (mode == skt_pkg::MODE_INSERT) begin
         if (hit) begin
            res.status = skt_pkg::STATUS_DUPLICATE;
            res.slot = at[skt_pkg::SLOT_W-1:0];
            res.found_pos = table_pos[at];
         end else if (table_fill >= skt_pkg::TABLE_DEPTH) begin
            res.status = skt_pkg::STATUS_FULL;
         end else begin
            at = table_fill;
            // shift larger entries up until the gap sits at the insert point
            while (at > 0 && key < table_key[at-1]) begin
               table_key[at] = table_key[at-1];
               table_pos[at] = table_pos[at-1];
               at--;
            end
            table_key[at] = key;
            table_pos[at] = pos;
            table_fill++;
            res.slot = at[skt_pkg::SLOT_W-1:0];
            res.found_pos = pos;
         end
      end else if (mode == skt_pkg::MODE_DELETE) begin
         if (!hit) begin
            res.status = skt_pkg::STATUS_NOT_FOUND;
         end else begin
            res.slot = at[skt_pkg::SLOT_W-1:0];
            res.found_pos = table_pos[at];
            for (int i = at; i + 1 < table_fill; i++) begin
               table_key[i] = table_key[i+1];
               table_pos[i] = table_pos[i+1];
            end
            table_fill--;
         end
      end else begin
         if (hit) begin
            res.slot = at[skt_pkg::SLOT_W-1:0];
            res.found_pos = table_pos[at];
         end else begin
            res.status = skt_pkg::STATUS_NOT_FOUND;
         end
      end
      res.fill = table_fill[skt_pkg::FILL_W-1:0];
      return res;
   endfunction

   // Queue a request and track which keys it leaves in the table.
   task automatic queue_request(input logic [skt_pkg::MODE_W-1:0] mode,
                                input logic [63:0] key,
                                input logic [skt_pkg::POS_W-1:0] pos, input int phase);
      int at;
      table_request_type req;
      at = -1;
      foreach (live_keys[i]) if (live_keys[i] == key) at = i;
      if (mode == skt_pkg::MODE_INSERT && at < 0 && live_keys.size() < skt_pkg::TABLE_DEPTH)
         live_keys.push_back(key);
      else if (mode == skt_pkg::MODE_DELETE && at >= 0)
         live_keys.delete(at);
      req.mode = mode;
      req.key = key;
      req.pos = pos;
      req.phase = phase;
      pending_requests.push_back(req);
   endtask

   function automatic logic [63:0] pick_key(input bit want_present);
      logic [63:0] k;
      int len;
      k = '0;
      if (want_present && live_keys.size() > 0) begin
         k = live_keys[$urandom_range(live_keys.size() - 1)];
      end else if ($urandom_range(1) == 0) begin
         k = {$urandom, $urandom};
      end else begin
         // short NUL-padded strings from a small alphabet, so neighbors collide
         len = $urandom_range(8, 1);
         for (int b = 0; b < len; b++) k[63 - 8*b -: 8] = 8'h61 + 8'($urandom_range(3));
      end
      return k;
   endfunction

   function automatic int send_idle_pct(input int phase);
      return (phase == 1) ? 69 : (phase == 3) ? 28 : 0;
   endfunction

   function automatic int recv_stall_pct(input int phase);
      return (phase == 2) ? 69 : (phase == 3) ? 28 : 0;
   endfunction

   // Driver: hold the beat while stalled, advance on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_to_table(pending_requests[0].mode,
                                                      pending_requests[0].key,
                                                      pending_requests[0].pos));
            pending_requests.pop_front();
            request_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0) drive_phase = pending_requests[0].phase;
            if (pending_requests.size() > 0 &&
                $urandom_range(99) >= send_idle_pct(drive_phase)) begin
               req_tvalid <= 1'b1;
               req_tdata <= {pending_requests[0].pos, pending_requests[0].key};
               req_tuser <= pending_requests[0].mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response beat against the oldest prediction.
   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            response_count++;
            status_seen[rsp_tuser]++;
            if (expected_results.size() == 0) begin
               $error("response beat with nothing expected: status %0d slot %0d",
                      rsp_tuser, rsp_tdata[5:0]);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[5:0] !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_tdata[5:0]);
                  error_count++;
               end
               if (rsp_tdata[37:6] !== want.found_pos) begin
                  $error("found_pos: expected %h, got %h", want.found_pos, rsp_tdata[37:6]);
                  error_count++;
               end
               if (rsp_tdata[44:38] !== want.fill) begin
                  $error("fill: expected %0d, got %0d", want.fill, rsp_tdata[44:38]);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct(drive_phase));
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_results.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      int r;
      logic [skt_pkg::MODE_W-1:0] mode;
      bit present;

      // directed: empty table, key extremes, padding after NUL, every mode
      queue_request(skt_pkg::MODE_LOOKUP, "ab", 32'h0, 0);
      queue_request(skt_pkg::MODE_DELETE, "ab", 32'hFFFF_FFFF, 0);
      queue_request(skt_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
      queue_request(skt_pkg::MODE_INSERT, 64'h0, 32'h0, 0);
      queue_request(skt_pkg::MODE_INSERT, {8'h4D, 56'h0}, 32'h1234_5678, 0);
      queue_request(skt_pkg::MODE_INSERT, {8'h4D, 48'h0, 8'h01}, 32'h8765_4321, 0);
      queue_request(skt_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0BAD_F00D, 0);
      queue_request(skt_pkg::MODE_LOOKUP, 64'h0, 32'hFFFF_FFFF, 0);
      queue_request(skt_pkg::MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0);
      queue_request(MODE_SPARE, {8'h4D, 56'h0}, 32'h0, 0);
      queue_request(MODE_SPARE, {8'h4E, 56'h0}, 32'h0, 0);
      queue_request(skt_pkg::MODE_LOOKUP, {8'h4C, 56'h0}, 32'h0, 0);
      queue_request(skt_pkg::MODE_DELETE, {8'h4D, 56'h0}, 32'h0, 0);
      queue_request(skt_pkg::MODE_DELETE, {8'h4D, 56'h0}, 32'h0, 0);
      queue_request(skt_pkg::MODE_LOOKUP, {8'h4D, 48'h0, 8'h01}, 32'h0, 0);
      queue_request(skt_pkg::MODE_DELETE, 64'h0, 32'h0, 0);
      queue_request(skt_pkg::MODE_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0);
      queue_request(skt_pkg::MODE_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_5555, 0);
      queue_request(skt_pkg::MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_AAAA, 0);
      queue_request(skt_pkg::MODE_LOOKUP, 64'h5555_5555_5555_5555, 32'h0, 0);
      queue_request(skt_pkg::MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0, 0);

      // random: each phase fills the table past full, then drains part of it
      for (int p = 0; p < PHASE_COUNT; p++) begin
         for (int n = 0; n < FILL_BEATS + DRAIN_BEATS; n++) begin
            r = $urandom_range(99);
            if (n < FILL_BEATS)
               mode = (r < 85) ? skt_pkg::MODE_INSERT : (r < 92) ? skt_pkg::MODE_LOOKUP :
                      (r < 96) ? skt_pkg::MODE_DELETE : MODE_SPARE;
            else
               mode = (r < 75) ? skt_pkg::MODE_DELETE : (r < 90) ? skt_pkg::MODE_LOOKUP :
                      (r < 95) ? skt_pkg::MODE_INSERT : MODE_SPARE;
            present = ($urandom_range(99) < ((mode == skt_pkg::MODE_INSERT) ? 15 : 65));
            queue_request(mode, pick_key(present), $urandom, p);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d responses over %0d idling phases",
               request_count, response_count, PHASE_COUNT);
      $display("statuses seen: ok %0d, not found %0d, duplicate %0d, full %0d",
               status_seen[skt_pkg::STATUS_OK], status_seen[skt_pkg::STATUS_NOT_FOUND],
               status_seen[skt_pkg::STATUS_DUPLICATE], status_seen[skt_pkg::STATUS_FULL]);
      if (error_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
